// ===== design/morse_key_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// morse key decoder assertion macros
// property shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef MORSE_KEY_DECODER_MACROS_SVH
`define MORSE_KEY_DECODER_MACROS_SVH

// same-cycle implication, off during reset
`define MKD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mkd assertion failed");

// next-cycle implication, off during reset
`define MKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mkd assertion failed");

`endif

// ===== design/mkd_pkg.sv =====
// ----------------------------------------------------------------------------
// mkd_pkg
// types, constants and the code lookup of the morse key decoder
// ----------------------------------------------------------------------------
package mkd_pkg;

    // elements held before the next press closes the letter
    localparam logic [2:0] MAX_ELEMENTS = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_DOT_LIMIT        = 2'd0;
    localparam logic [1:0] CFG_LETTER_GAP_LIMIT = 2'd1;
    localparam logic [1:0] CFG_WORD_GAP_LIMIT   = 2'd2;

    // character for code i sits at byte (63 - i) counted from the lsb
    localparam logic [64*8-1:0] LETTER_TABLE =
        "##TEMNAIOGKDWRUS##QZYCXBJP#L#FVH09#8###7#######61#######2###3#45";

    // punctuation codes above the table
    localparam logic [6:0] CODE_COLON    = 7'd71;
    localparam logic [6:0] CODE_COMMA    = 7'd76;
    localparam logic [6:0] CODE_EXCLAIM  = 7'd84;
    localparam logic [6:0] CODE_DASH     = 7'd94;
    localparam logic [6:0] CODE_AT       = 7'd101;
    localparam logic [6:0] CODE_PERIOD   = 7'd106;
    localparam logic [6:0] CODE_QUESTION = 7'd115;

    localparam logic [7:0] CH_COLON    = ":";
    localparam logic [7:0] CH_COMMA    = ",";
    localparam logic [7:0] CH_EXCLAIM  = "!";
    localparam logic [7:0] CH_DASH     = "-";
    localparam logic [7:0] CH_AT       = "@";
    localparam logic [7:0] CH_PERIOD   = ".";
    localparam logic [7:0] CH_QUESTION = "?";
    localparam logic [7:0] CH_UNKNOWN  = "#";

    typedef struct packed {
        logic [6:0] char_code;
        logic       word_break;
    } mkd_result_t;

    function automatic logic [6:0] lookup_code(input logic [6:0] code);
        logic [6:0] ch;
        ch = CH_UNKNOWN[6:0];
        if (!code[6]) begin
            // 63 - index is the bitwise inverse on six bits
            ch = LETTER_TABLE[{~code[5:0], 3'b000} +: 7];
        end
        else begin
            case (code)
                CODE_COLON:    ch = CH_COLON[6:0];
                CODE_COMMA:    ch = CH_COMMA[6:0];
                CODE_EXCLAIM:  ch = CH_EXCLAIM[6:0];
                CODE_DASH:     ch = CH_DASH[6:0];
                CODE_AT:       ch = CH_AT[6:0];
                CODE_PERIOD:   ch = CH_PERIOD[6:0];
                CODE_QUESTION: ch = CH_QUESTION[6:0];
                default:       ch = CH_UNKNOWN[6:0];
            endcase
        end
        return ch;
    endfunction

endpackage

// ===== design/mkd_out_buf.sv =====
// ----------------------------------------------------------------------------
// mkd_out_buf
// two-entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
module mkd_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mkd_pkg::mkd_result_t push_data,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output mkd_pkg::mkd_result_t out_data
);
    import mkd_pkg::*;

    logic        out_valid_reg;
    logic        out_valid_next;
    mkd_result_t out_data_reg;
    mkd_result_t out_data_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    mkd_result_t skid_data_reg;
    mkd_result_t skid_data_next;
    logic        pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            // no push while full
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
        else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/morse_key_decoder.sv =====
// ----------------------------------------------------------------------------
// morse_key_decoder
// decodes a sampled morse key into ascii characters
// ----------------------------------------------------------------------------
// One word is one tick sample of the key and the block takes one word every
// clock. Press and gap lengths are counted in ticks (saturating at 255); a
// letter is decoded when the press after a long enough gap, or after six
// elements, is taken, and its character is pushed into the result buffer.
// Results leave through a two-entry buffer, so input is stalled only when
// two results wait behind a stalled output. The user writes the three limits
// through the config port while the block is idle, which is not enforced.
// ----------------------------------------------------------------------------
module morse_key_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       key_down,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] char_code,
    output logic       word_break,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import mkd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PRESS = 2'd1,
        PH_GAP   = 2'd2
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  tick_count_reg;
    logic [7:0]  tick_count_next;
    logic [6:0]  code_accum_reg;
    logic [6:0]  code_accum_next;
    logic [2:0]  element_count_reg;
    logic [2:0]  element_count_next;
    logic [7:0]  dot_limit_reg;
    logic [7:0]  letter_gap_limit_reg;
    logic [7:0]  word_gap_limit_reg;

    logic        accept;
    logic        emit;
    logic        buf_full;
    logic [7:0]  tick_inc;
    mkd_result_t result;
    mkd_result_t out_data;

    assign accept   = in_valid && !buf_full;
    assign in_stall = buf_full;
    assign tick_inc = (tick_count_reg == 8'hFF) ? tick_count_reg : tick_count_reg + 8'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        tick_count_next    = tick_count_reg;
        code_accum_next    = code_accum_reg;
        element_count_next = element_count_reg;
        emit               = 1'b0;
        result.char_code   = lookup_code(code_accum_reg);
        result.word_break  = (tick_count_reg >= word_gap_limit_reg);
        case (phase_reg)
            PH_PRESS:
            begin
                if (key_down) begin
                    tick_count_next = tick_inc;
                end
                else begin
                    // short press is a dot (1), long one a dash (0)
                    code_accum_next = {code_accum_reg[5:0], tick_count_reg < dot_limit_reg};
                    if (element_count_reg != 3'd7) begin
                        element_count_next = element_count_reg + 3'd1;
                    end
                    phase_next      = PH_GAP;
                    tick_count_next = 8'd1;
                end
            end
            PH_GAP:
            begin
                if (!key_down) begin
                    tick_count_next = tick_inc;
                end
                else begin
                    if (tick_count_reg >= letter_gap_limit_reg
                        || element_count_reg >= MAX_ELEMENTS) begin
                        emit               = 1'b1;
                        code_accum_next    = 7'd1;
                        element_count_next = 3'd0;
                    end
                    phase_next      = PH_PRESS;
                    tick_count_next = 8'd1;
                end
            end
            default:
            begin
                // idle and the unused code both wait for a press
                if (key_down) begin
                    phase_next         = PH_PRESS;
                    tick_count_next    = 8'd1;
                    code_accum_next    = 7'd1;
                    element_count_next = 3'd0;
                end
                else begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg         <= PH_IDLE;
            tick_count_reg    <= 8'd0;
            code_accum_reg    <= 7'd1;
            element_count_reg <= 3'd0;
        end
        else if (accept) begin
            phase_reg         <= phase_next;
            tick_count_reg    <= tick_count_next;
            code_accum_reg    <= code_accum_next;
            element_count_reg <= element_count_next;
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dot_limit_reg        <= 8'd2;
            letter_gap_limit_reg <= 8'd3;
            word_gap_limit_reg   <= 8'd6;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DOT_LIMIT:        dot_limit_reg        <= cfg_data;
                CFG_LETTER_GAP_LIMIT: letter_gap_limit_reg <= cfg_data;
                CFG_WORD_GAP_LIMIT:   word_gap_limit_reg   <= cfg_data;
                default:              ;
            endcase
        end
    end

    mkd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && emit),
        .push_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign char_code  = out_data.char_code;
    assign word_break = out_data.word_break;

endmodule

// ===== design/mkd_checker.sv =====
// ----------------------------------------------------------------------------
// mkd_checker
// port-level checks of the morse key decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "morse_key_decoder_macros.svh"

module mkd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [6:0] char_code,
    input logic       word_break
);

    logic       out_waits;
    logic [7:0] out_word;

    assign out_waits = out_valid && out_stall;
    assign out_word  = {char_code, word_break};

    // stalled result holds
    `MKD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_waits, out_valid && $stable(out_word))

    // input stalls only with a result waiting at the output
    `MKD_ASSERT_IMPL(a_stall_needs_out, clk, rst_n, in_stall, out_valid)

    // a new result follows an accepted word
    `MKD_ASSERT_IMPL(a_out_from_input, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall))

    // buffer fills only behind a stalled output
    `MKD_ASSERT_IMPL(a_stall_cause, clk, rst_n, $rose(in_stall), $past(out_valid && out_stall))

    // every decoded character is nonzero
    `MKD_ASSERT_IMPL(a_char_nonzero, clk, rst_n, out_valid, char_code != 7'd0)

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (.*);
